// ===== hw/rtl/smm_pkg.sv =====
// Shared types and constants for the saturating byte matrix multiply block
`default_nettype none

package smm_pkg;

  // Widths of the item fields
  localparam int IDX_W = 3;
  localparam int VAL_W = 8;
  localparam int DIM_W = 4;
  localparam int PROD_W = 2 * VAL_W;
  // Eight products of 255 x 255 fit in 20 bits
  localparam int ACC_W = 20;

  localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;
  localparam logic [VAL_W-1:0] SAT_MAX = 8'd255;

  // Operation codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_LOAD_A  = 2'd0,
    OP_LOAD_B  = 2'd1,
    OP_COMPUTE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  // Configuration register indexes
  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd_en;
    logic             acc_clr;
    logic             emit;
    logic             emit_err;
    logic             emit_last;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] k;
  } smm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic busy;
    logic out_free;
  } smm_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/smm_ctrl.sv =====
// Controller: configuration registers, operation decode and product walk sequencer
`default_nettype none

module smm_ctrl import smm_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [DIM_W-1:0]  cfg_wdata,
  input  wire logic              in_tvalid,
  output      logic              in_tready,
  input  wire logic [1:0]        in_op,
  input  wire logic [IDX_W-1:0]  in_row,
  input  wire logic [IDX_W-1:0]  in_col,
  output      smm_cmd_t          cmd,
  input  wire smm_status_t       st
);

  localparam logic [DIM_W-1:0] MaxDim = DIM_W'(MAX_DIM);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_EMIT,
    S_ERR
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [DIM_W-1:0] a_rows_r, a_cols_r, b_rows_r, b_cols_r;
  logic [DIM_W-1:0] ar, ac, br, bc;
  logic             accept;
  logic             in_range;
  logic             last_k, last_j, last_i;
  op_t              op;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > MaxDim) r = MaxDim;
    return r;
  endfunction

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= DIM_RESET;
      a_cols_r <= DIM_RESET;
      b_rows_r <= DIM_RESET;
      b_cols_r <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_A_ROWS: a_rows_r <= cfg_wdata;
        REG_A_COLS: a_cols_r <= cfg_wdata;
        REG_B_ROWS: b_rows_r <= cfg_wdata;
        REG_B_COLS: b_cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign ar = clamp_dim(a_rows_r);
  assign ac = clamp_dim(a_cols_r);
  assign br = clamp_dim(b_rows_r);
  assign bc = clamp_dim(b_cols_r);

  assign op        = op_t'(in_op);
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign in_range  = ({1'b0, in_row} < MaxDim) && ({1'b0, in_col} < MaxDim);

  assign last_k = ({1'b0, k_r} == ac - DIM_W'(1));
  assign last_j = ({1'b0, j_r} == bc - DIM_W'(1));
  assign last_i = ({1'b0, i_r} == ar - DIM_W'(1));

  // Next state and counters
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    case (state_r)
      S_IDLE: begin
        if (accept && op == OP_COMPUTE) begin
          i_nxt = '0;
          j_nxt = '0;
          k_nxt = '0;
          state_nxt = (ac != br) ? S_ERR : S_MAC;
        end
      end
      S_MAC: begin
        if (last_k) begin
          k_nxt = '0;
          state_nxt = S_DRAIN;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (!st.busy) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          if (last_j && last_i) begin
            state_nxt = S_IDLE;
          end else if (last_j) begin
            j_nxt = '0;
            i_nxt = i_r + IDX_W'(1);
            state_nxt = S_MAC;
          end else begin
            j_nxt = j_r + IDX_W'(1);
            state_nxt = S_MAC;
          end
        end
      end
      S_ERR: begin
        if (st.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and loop counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  // Datapath commands
  always_comb begin
    cmd           = '0;
    cmd.wr_a      = accept && op == OP_LOAD_A && in_range;
    cmd.wr_b      = accept && op == OP_LOAD_B && in_range;
    cmd.rd_en     = (state_r == S_MAC);
    cmd.emit      = (state_r == S_EMIT || state_r == S_ERR) && st.out_free;
    cmd.acc_clr   = (accept && op == OP_COMPUTE) || cmd.emit;
    cmd.emit_err  = (state_r == S_ERR);
    cmd.emit_last = (state_r == S_ERR) || (last_i && last_j);
    cmd.row       = (state_r == S_ERR) ? '0 : i_r;
    cmd.col       = (state_r == S_ERR) ? '0 : j_r;
    cmd.k         = k_r;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/smm_dp.sv =====
// Datapath: element stores, multiply-accumulate pipeline and output register
`default_nettype none

module smm_dp import smm_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire smm_cmd_t          cmd,
  output      smm_status_t       st,
  input  wire logic [IDX_W-1:0]  in_row,
  input  wire logic [IDX_W-1:0]  in_col,
  input  wire logic [VAL_W-1:0]  in_value,
  output      logic              out_tvalid,
  input  wire logic              out_tready,
  output      logic [IDX_W-1:0]  out_row,
  output      logic [IDX_W-1:0]  out_col,
  output      logic [VAL_W-1:0]  out_value,
  output      logic              out_err,
  output      logic              out_last
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LIN_W = 2 * IDX_W + 1;

  logic [VAL_W-1:0]  a_mem [DEPTH];
  logic [VAL_W-1:0]  b_mem [DEPTH];
  logic [AW-1:0]     wr_addr, a_rd_addr, b_rd_addr;
  logic [VAL_W-1:0]  a_q_r, b_q_r;
  logic              rd_vld_r, prod_vld_r;
  logic [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]  acc_r;
  logic              out_vld_r;
  logic [IDX_W-1:0]  out_row_r, out_col_r;
  logic [VAL_W-1:0]  out_value_r;
  logic              out_err_r, out_last_r;
  logic [VAL_W-1:0]  sat_value;

  function automatic logic [AW-1:0] lin_addr(input logic [IDX_W-1:0] r,
                                             input logic [IDX_W-1:0] c);
    logic [LIN_W-1:0] lin;
    lin = LIN_W'(r) * LIN_W'(MAX_DIM) + LIN_W'(c);
    return lin[AW-1:0];
  endfunction

  assign wr_addr   = lin_addr(in_row, in_col);
  assign a_rd_addr = lin_addr(cmd.row, cmd.k);
  assign b_rd_addr = lin_addr(cmd.k, cmd.col);

  // Element stores with registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_a) a_mem[wr_addr] <= in_value;
    if (cmd.wr_b) b_mem[wr_addr] <= in_value;
    a_q_r <= a_mem[a_rd_addr];
    b_q_r <= b_mem[b_rd_addr];
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    prod_r <= a_q_r * b_q_r;
  end

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= cmd.rd_en;
      prod_vld_r <= rd_vld_r;
    end
  end

  // Accumulate at full width
  always_ff @(posedge clk) begin
    if (cmd.acc_clr) acc_r <= '0;
    else if (prod_vld_r) acc_r <= acc_r + ACC_W'(prod_r);
  end

  assign sat_value = (acc_r > ACC_W'(SAT_MAX)) ? SAT_MAX : acc_r[VAL_W-1:0];

  // Output register: load on emit, drop after the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_r   <= cmd.row;
      out_col_r   <= cmd.col;
      out_value_r <= cmd.emit_err ? '0 : sat_value;
      out_err_r   <= cmd.emit_err;
      out_last_r  <= cmd.emit_last;
    end
  end

  assign st.busy     = rd_vld_r || prod_vld_r;
  assign st.out_free = !out_vld_r || out_tready;

  assign out_tvalid = out_vld_r;
  assign out_row    = out_row_r;
  assign out_col    = out_col_r;
  assign out_value  = out_value_r;
  assign out_err    = out_err_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

// ===== hw/rtl/saturating_byte_matrix_multiply_top.sv =====
// Top level of the saturating byte matrix multiply block
`default_nettype none

// Holds two byte matrices A and B of up to MAX_DIM x MAX_DIM elements. A load
// transfer (operation 0 for A, 1 for B) writes one element; loads may follow
// each other in every cycle while the block is idle. A compute transfer
// (operation 2) walks A times B over the configured dimensions and emits each
// element in row-major order, saturated to 255, with tlast on the final one.
// The input stays not ready during the walk. Each product element passes
// through the single multiply-accumulate unit, which reads one element of each
// store per cycle. If a_cols and b_rows differ, compute emits one error result
// (tuser set, tlast set, zero data). Dimension registers read 0 as 1 and clamp
// above MAX_DIM. Write configuration only while the block is idle. Stores are
// not cleared at reset.
module saturating_byte_matrix_multiply_top import smm_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [DIM_W-1:0]  cfg_wdata,
  input  wire logic              in_tvalid,
  output      logic              in_tready,
  input  wire logic [15:0]       in_tdata,   // row_index[2:0], col_index[5:3],
                                             // element_value[13:6], zero fill
  input  wire logic [1:0]        in_tuser,   // operation[1:0]
  output      logic              out_tvalid,
  input  wire logic              out_tready,
  output      logic [15:0]       out_tdata,  // out_row[2:0], out_col[5:3],
                                             // product_value[13:6], zero fill
  output      logic [0:0]        out_tuser,  // dims_error[0]
  output      logic              out_tlast
);

  smm_cmd_t         cmd;
  smm_status_t      st;
  logic [IDX_W-1:0] in_row, in_col;
  logic [VAL_W-1:0] in_value;
  logic [IDX_W-1:0] out_row, out_col;
  logic [VAL_W-1:0] out_value;
  logic             out_err;

  assign in_row   = in_tdata[2:0];
  assign in_col   = in_tdata[5:3];
  assign in_value = in_tdata[13:6];

  smm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_op     (in_tuser),
    .in_row    (in_row),
    .in_col    (in_col),
    .cmd       (cmd),
    .st        (st)
  );

  smm_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_row     (in_row),
    .in_col     (in_col),
    .in_value   (in_value),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (out_value),
    .out_err    (out_err),
    .out_last   (out_tlast)
  );

  assign out_tdata = {2'b00, out_value, out_col, out_row};
  assign out_tuser = out_err;

  // A result is loaded only into a free output slot
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.out_free)
    else $error("emit into an occupied output register");

  // New items are taken only with the multiply pipeline empty
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !st.busy && !cmd.rd_en)
    else $error("input ready while the product walk is active");

  // An error result is a single run with zero payload
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && out_tdata == 16'h0000)
    else $error("malformed dimension error result");

endmodule

`default_nettype wire
